@@ hdl/hts_pkg.sv @@
// Shared types, codes and helper function of the two-axis homing sequencer.
package hts_pkg;

    localparam int SEARCH_W  = 24;
    localparam int OFFSET_W  = 23;
    localparam int TIMEOUT_W = 32;
    localparam int NOW_W     = 32;
    localparam int MOVE_W    = 25;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [SEARCH_W-1:0]  SEARCH_RESET  = 24'd100000;
    localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = 23'd1000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd60000;

    localparam logic [CFG_IDX_W-1:0] REG_SEARCH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_MOVE     = 3'd1;
    localparam logic [2:0] CMD_STOP_ALL = 3'd2;
    localparam logic [2:0] CMD_STOP_AZ  = 3'd3;
    localparam logic [2:0] CMD_STOP_ALT = 3'd4;

    localparam logic [1:0] SPEED_KEEP = 2'd0;
    localparam logic [1:0] SPEED_FAST = 2'd1;
    localparam logic [1:0] SPEED_SLOW = 2'd2;
    localparam logic [1:0] SPEED_MAX  = 2'd3;

    localparam logic [1:0] ACCEL_KEEP    = 2'd0;
    localparam logic [1:0] ACCEL_HOMING  = 2'd1;
    localparam logic [1:0] ACCEL_DEFAULT = 2'd2;

    localparam logic [1:0] ZERO_NONE = 2'd0;
    localparam logic [1:0] ZERO_AZ   = 2'd1;
    localparam logic [1:0] ZERO_ALT  = 2'd2;

    localparam logic [1:0] MODE_KEEP   = 2'd0;
    localparam logic [1:0] MODE_IDLE   = 2'd1;
    localparam logic [1:0] MODE_HOMING = 2'd2;
    localparam logic [1:0] MODE_ERROR  = 2'd3;

    typedef enum logic [11:0] {
        PH_IDLE     = 12'b0000_0000_0001,
        PH_AZ_FAST  = 12'b0000_0000_0010,
        PH_AZ_BACK  = 12'b0000_0000_0100,
        PH_AZ_SLOW  = 12'b0000_0000_1000,
        PH_AZ_ZERO  = 12'b0000_0001_0000,
        PH_ALT_FAST = 12'b0000_0010_0000,
        PH_ALT_BACK = 12'b0000_0100_0000,
        PH_ALT_SLOW = 12'b0000_1000_0000,
        PH_ALT_ZERO = 12'b0001_0000_0000,
        PH_OFFSET   = 12'b0010_0000_0000,
        PH_DONE     = 12'b0100_0000_0000,
        PH_ERROR    = 12'b1000_0000_0000
    } hts_phase_t;

    typedef struct packed {
        logic [SEARCH_W-1:0]  search_distance;
        logic [OFFSET_W-1:0]  offset_steps;
        logic [TIMEOUT_W-1:0] timeout_ms;
    } hts_cfg_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [NOW_W-1:0] now_ms;
        logic             az_switch;
        logic             alt_switch;
        logic             motion_busy;
        logic             estop;
    } hts_item_t;

    typedef struct packed {
        hts_phase_t phase;
        logic       active;
        logic       done;
        logic       limits;
    } hts_state_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [MOVE_W-1:0] move_az;
        logic [MOVE_W-1:0] move_alt;
        logic [1:0]        speed_select;
        logic [1:0]        accel_select;
        logic              drivers_enable;
        logic              limits_enabled;
        logic [1:0]        zero_axis;
        logic [1:0]        motion_mode;
        logic              homing_active;
        logic              homed_flag;
        logic [3:0]        phase;
    } hts_result_t;

    // Numeric phase code as reported on the result.
    function automatic logic [3:0] phase_code(hts_phase_t ph);
        logic [3:0] code;
        unique case (ph)
            PH_IDLE:     code = 4'd0;
            PH_AZ_FAST:  code = 4'd1;
            PH_AZ_BACK:  code = 4'd2;
            PH_AZ_SLOW:  code = 4'd3;
            PH_AZ_ZERO:  code = 4'd4;
            PH_ALT_FAST: code = 4'd5;
            PH_ALT_BACK: code = 4'd6;
            PH_ALT_SLOW: code = 4'd7;
            PH_ALT_ZERO: code = 4'd8;
            PH_OFFSET:   code = 4'd9;
            PH_DONE:     code = 4'd10;
            PH_ERROR:    code = 4'd11;
            default:     code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/hts_cfg.sv @@
// Configuration register file of the homing sequencer.
module hts_cfg
    import hts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output hts_cfg_t             cfg
);

    hts_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.search_distance <= SEARCH_RESET;
            cfg_reg.offset_steps    <= OFFSET_RESET;
            cfg_reg.timeout_ms      <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEARCH:  cfg_reg.search_distance <= cfg_data[SEARCH_W-1:0];
                REG_OFFSET:  cfg_reg.offset_steps    <= cfg_data[OFFSET_W-1:0];
                REG_TIMEOUT: cfg_reg.timeout_ms      <= cfg_data[TIMEOUT_W-1:0];
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/hts_step.sv @@
// Next-state and result logic for one request of the homing sequencer.
module hts_step
    import hts_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  hts_item_t            item,
    input  hts_state_t           state,
    input  logic [TIME_BITS-1:0] start_time,
    input  hts_cfg_t             cfg,
    output hts_state_t           state_next,
    output logic                 start_load,
    output logic [TIME_BITS-1:0] start_value,
    output hts_result_t          result
);

    // Compare width covers both the elapsed time and the timeout register.
    localparam int CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 timed_out;
    logic [MOVE_W-1:0]    neg_search;
    logic [MOVE_W-1:0]    neg_slow;
    logic [MOVE_W-1:0]    offset_ext;
    hts_state_t           ns;
    logic [2:0]           cmd;
    logic [MOVE_W-1:0]    maz;
    logic [MOVE_W-1:0]    malt;
    logic [1:0]           speed;
    logic [1:0]           accel;
    logic                 drv;
    logic [1:0]           zero;
    logic [1:0]           mode;
    logic                 go_error;
    logic [2:0]           error_cmd;

    always_comb
    begin
        if (TIME_BITS >= NOW_W)
            now_t = TIME_BITS'(item.now_ms);
        else
            now_t = item.now_ms[TIME_BITS-1:0];
    end

    assign elapsed    = now_t - start_time;
    assign timed_out  = CMP_W'(elapsed) > CMP_W'(cfg.timeout_ms);
    assign neg_search = MOVE_W'(0) - MOVE_W'(cfg.search_distance);
    assign neg_slow   = MOVE_W'(0) - MOVE_W'({cfg.offset_steps, 1'b0});
    assign offset_ext = MOVE_W'(cfg.offset_steps);

    always_comb
    begin
        ns        = state;
        cmd       = CMD_NONE;
        maz       = '0;
        malt      = '0;
        speed     = SPEED_KEEP;
        accel     = ACCEL_KEEP;
        drv       = 1'b0;
        zero      = ZERO_NONE;
        mode      = MODE_KEEP;
        go_error  = 1'b0;
        error_cmd = CMD_NONE;
        start_load = 1'b0;

        case (item.op)
            OP_START:
            begin
                if (!state.active)
                begin
                    drv        = 1'b1;
                    ns.limits  = 1'b0;
                    speed      = SPEED_FAST;
                    accel      = ACCEL_HOMING;
                    ns.active  = 1'b1;
                    ns.done    = 1'b0;
                    start_load = 1'b1;
                    cmd        = CMD_MOVE;
                    maz        = neg_search;
                    mode       = MODE_HOMING;
                    ns.phase   = PH_AZ_FAST;
                end
            end
            OP_STOP:
            begin
                if (state.active)
                begin
                    cmd       = CMD_STOP_ALL;
                    ns.limits = 1'b1;
                    ns.active = 1'b0;
                    ns.done   = 1'b0;
                    ns.phase  = PH_IDLE;
                    speed     = SPEED_MAX;
                    accel     = ACCEL_DEFAULT;
                    mode      = MODE_IDLE;
                end
            end
            OP_UPDATE:
            begin
                if (state.active)
                begin
                    if (item.estop)
                    begin
                        go_error  = 1'b1;
                        error_cmd = CMD_NONE;
                    end
                    else if (timed_out)
                    begin
                        go_error  = 1'b1;
                        error_cmd = CMD_STOP_ALL;
                    end
                    else
                    begin
                        unique case (state.phase)
                            PH_AZ_FAST:
                            begin
                                if (item.az_switch)
                                begin
                                    cmd      = CMD_STOP_AZ;
                                    ns.phase = PH_AZ_BACK;
                                end
                            end
                            PH_ALT_FAST:
                            begin
                                if (item.alt_switch)
                                begin
                                    cmd      = CMD_STOP_ALT;
                                    ns.phase = PH_ALT_BACK;
                                end
                            end
                            PH_AZ_BACK:
                            begin
                                if (!item.motion_busy)
                                begin
                                    speed    = SPEED_FAST;
                                    cmd      = CMD_MOVE;
                                    maz      = offset_ext;
                                    mode     = MODE_HOMING;
                                    ns.phase = PH_AZ_SLOW;
                                end
                            end
                            PH_ALT_BACK:
                            begin
                                if (!item.motion_busy)
                                begin
                                    speed    = SPEED_FAST;
                                    cmd      = CMD_MOVE;
                                    malt     = offset_ext;
                                    mode     = MODE_HOMING;
                                    ns.phase = PH_ALT_SLOW;
                                end
                            end
                            PH_AZ_SLOW:
                            begin
                                if (!item.motion_busy)
                                begin
                                    speed    = SPEED_SLOW;
                                    cmd      = CMD_MOVE;
                                    maz      = neg_slow;
                                    mode     = MODE_HOMING;
                                    ns.phase = PH_AZ_ZERO;
                                end
                            end
                            PH_ALT_SLOW:
                            begin
                                if (!item.motion_busy)
                                begin
                                    speed    = SPEED_SLOW;
                                    cmd      = CMD_MOVE;
                                    malt     = neg_slow;
                                    mode     = MODE_HOMING;
                                    ns.phase = PH_ALT_ZERO;
                                end
                            end
                            PH_AZ_ZERO:
                            begin
                                if (item.az_switch)
                                begin
                                    if (item.motion_busy)
                                        cmd = CMD_STOP_AZ;
                                    else
                                    begin
                                        zero     = ZERO_AZ;
                                        speed    = SPEED_FAST;
                                        cmd      = CMD_MOVE;
                                        malt     = neg_search;
                                        mode     = MODE_HOMING;
                                        ns.phase = PH_ALT_FAST;
                                    end
                                end
                                else if (!item.motion_busy)
                                begin
                                    go_error  = 1'b1;
                                    error_cmd = CMD_STOP_ALL;
                                end
                            end
                            PH_ALT_ZERO:
                            begin
                                if (item.alt_switch)
                                begin
                                    if (item.motion_busy)
                                        cmd = CMD_STOP_ALT;
                                    else
                                    begin
                                        zero     = ZERO_ALT;
                                        speed    = SPEED_FAST;
                                        cmd      = CMD_MOVE;
                                        maz      = offset_ext;
                                        malt     = offset_ext;
                                        mode     = MODE_HOMING;
                                        ns.phase = PH_OFFSET;
                                    end
                                end
                                else if (!item.motion_busy)
                                begin
                                    go_error  = 1'b1;
                                    error_cmd = CMD_STOP_ALL;
                                end
                            end
                            PH_OFFSET:
                            begin
                                if (!item.motion_busy)
                                begin
                                    speed     = SPEED_MAX;
                                    accel     = ACCEL_DEFAULT;
                                    ns.limits = 1'b1;
                                    ns.phase  = PH_DONE;
                                end
                            end
                            PH_DONE:
                            begin
                                ns.done   = 1'b1;
                                ns.active = 1'b0;
                                mode      = MODE_IDLE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Abort path shared by e-stop, timeout and a failed slow approach.
        if (go_error)
        begin
            cmd       = error_cmd;
            maz       = '0;
            malt      = '0;
            ns.limits = 1'b1;
            speed     = SPEED_MAX;
            accel     = ACCEL_DEFAULT;
            ns.active = 1'b0;
            ns.done   = 1'b0;
            ns.phase  = PH_ERROR;
            mode      = MODE_ERROR;
        end
    end

    assign state_next  = ns;
    assign start_value = now_t;

    assign result.command        = cmd;
    assign result.move_az        = maz;
    assign result.move_alt       = malt;
    assign result.speed_select   = speed;
    assign result.accel_select   = accel;
    assign result.drivers_enable = drv;
    assign result.limits_enabled = ns.limits;
    assign result.zero_axis      = zero;
    assign result.motion_mode    = mode;
    assign result.homing_active  = ns.active;
    assign result.homed_flag     = ns.done;
    assign result.phase          = phase_code(ns.phase);

endmodule

@@ hdl/two_axis_homing_sequencer.sv @@
// Top level of the two-axis homing sequencer: request register, state and result register.
// A request moves from the request register to the result register. Throughput: one request
// per cycle unless the output stalls, set by the single next-state pass between the request
// and result registers; one more request may enter while a result waits on a stalled output.
// Reset (rst_n, asynchronous, active low) empties both registers, returns the phase to idle,
// clears the active and homed flags, re-enables the limits and reloads the configuration.
module two_axis_homing_sequencer
    import hts_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [NOW_W-1:0]     now_ms,
    input  logic                 az_switch,
    input  logic                 alt_switch,
    input  logic                 motion_busy,
    input  logic                 estop,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           command,
    output logic [MOVE_W-1:0]    move_az,
    output logic [MOVE_W-1:0]    move_alt,
    output logic [1:0]           speed_select,
    output logic [1:0]           accel_select,
    output logic                 drivers_enable,
    output logic                 limits_enabled,
    output logic [1:0]           zero_axis,
    output logic [1:0]           motion_mode,
    output logic                 homing_active,
    output logic                 homed_flag,
    output logic [3:0]           phase
);

    hts_cfg_t             cfg;
    hts_item_t            item_reg;
    logic                 item_valid_reg;
    hts_state_t           state_reg;
    hts_state_t           state_next;
    logic [TIME_BITS-1:0] start_time_reg;
    logic                 start_load;
    logic [TIME_BITS-1:0] start_value;
    hts_result_t          result_next;
    hts_result_t          result_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 in_take;

    // The request register moves into the result register whenever the result
    // register is empty or its content is being taken this cycle.
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    hts_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hts_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step
    (
        .item        (item_reg),
        .state       (state_reg),
        .start_time  (start_time_reg),
        .cfg         (cfg),
        .state_next  (state_next),
        .start_load  (start_load),
        .start_value (start_value),
        .result      (result_next)
    );

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_take)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op          <= op;
            item_reg.now_ms      <= now_ms;
            item_reg.az_switch   <= az_switch;
            item_reg.alt_switch  <= alt_switch;
            item_reg.motion_busy <= motion_busy;
            item_reg.estop       <= estop;
        end
    end

    // Sequencer state is committed exactly when a request moves to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase  <= PH_IDLE;
            state_reg.active <= 1'b0;
            state_reg.done   <= 1'b0;
            state_reg.limits <= 1'b1;
            start_time_reg   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            if (start_load)
                start_time_reg <= start_value;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign command        = result_reg.command;
    assign move_az        = result_reg.move_az;
    assign move_alt       = result_reg.move_alt;
    assign speed_select   = result_reg.speed_select;
    assign accel_select   = result_reg.accel_select;
    assign drivers_enable = result_reg.drivers_enable;
    assign limits_enabled = result_reg.limits_enabled;
    assign zero_axis      = result_reg.zero_axis;
    assign motion_mode    = result_reg.motion_mode;
    assign homing_active  = result_reg.homing_active;
    assign homed_flag     = result_reg.homed_flag;
    assign phase          = result_reg.phase;

endmodule
